[hw/rtl/hts_pkg.sv]
// Package for the histogram top-k selector: beat types, register indexes,
// fixed field widths and register reset values. No dependencies.
package hts_pkg;

  localparam int SLOT_W      = 6;
  localparam int ROOM_W      = 5;
  localparam int COUNT_OUT_W = 10;
  localparam int RANK_W      = 4;
  localparam int MAX_OPT_W   = 5;
  localparam int MIN_COUNT_W = 10;
  localparam int TSU_W       = 7;
  localparam int VU_W        = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_OPTION_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESLOTS_USED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VENUES_USED    = 2'd3;

  localparam logic [MAX_OPT_W-1:0]   OPTION_LIMIT_RST   = 5'd8;
  localparam logic [MIN_COUNT_W-1:0] MIN_COUNT_RST      = 10'd5;
  localparam logic [TSU_W-1:0]       TIMESLOTS_USED_RST = 7'd64;
  localparam logic [VU_W-1:0]        VENUES_USED_RST    = 6'd32;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [ROOM_W-1:0] room_index;
    logic              end_of_session;
  } pair_t;

  typedef struct packed {
    logic                   found;
    logic [SLOT_W-1:0]      chosen_slot;
    logic [ROOM_W-1:0]      chosen_room;
    logic [COUNT_OUT_W-1:0] chosen_count;
    logic [RANK_W-1:0]      rank;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

endpackage

[hw/rtl/hts_chan_if.sv]
// Valid/ready channel interface carrying one beat of a given payload type.
// Used with the beat types of hts_pkg.
interface hts_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/hts_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hts_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/histogram_top_k_selector.sv]
// Histogram top-k selector top level: pair accumulation, selection sequencer,
// result register and configuration registers. Uses hts_pkg, hts_chan_if, hts_ram.
//
// Usage:
//   pairs   (sink)   one (slot_index, room_index, end_of_session) beat per cycle
//                    while accumulating; each in-range pair bumps its histogram
//                    cell through a read-modify-write with forwarding.
//   results (source) one beat per selected cell, in rank order; the final beat
//                    of a session has last_result set. found=0 when no cell
//                    qualifies.
//   cfg     (sink)   register writes, always ready; write only while idle.
// Throughput: one pair per cycle. After the end_of_session beat, pairs.ready
// stays low while the shared scan runs: each round reads every active cell
// through the single RAM read port, for up to min(option_limit, MAX_OPTIONS)
// rounds. Then a clear pass writes zero to all TIMESLOTS*VENUES cells, one per
// cycle, before the next pair.
// Reset: loads register defaults and runs the same clear pass.
// Receiver stall: the result register holds its beat; the sequencer waits
// before pushing the next result.
module histogram_top_k_selector #(
  parameter int TIMESLOTS   = 64,
  parameter int VENUES      = 32,
  parameter int MAX_OPTIONS = 16,
  parameter int COUNT_MAX   = 1023
) (
  input  logic       clk,
  input  logic       rst,
  hts_chan_if.sink   pairs,
  hts_chan_if.source results,
  hts_chan_if.sink   cfg
);

  localparam int CELLS  = TIMESLOTS * VENUES;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(COUNT_MAX + 1);
  localparam int WORD_W = CNT_W + 1;
  localparam int CMP_W  = (CNT_W > hts_pkg::MIN_COUNT_W) ? CNT_W : hts_pkg::MIN_COUNT_W;
  localparam int RA_W   = ($clog2(TIMESLOTS + 1) > hts_pkg::TSU_W) ?
                          $clog2(TIMESLOTS + 1) : hts_pkg::TSU_W;
  localparam int CA_W   = ($clog2(VENUES + 1) > hts_pkg::VU_W) ?
                          $clog2(VENUES + 1) : hts_pkg::VU_W;
  localparam int RND_W  = ($clog2(MAX_OPTIONS + 1) > hts_pkg::MAX_OPT_W) ?
                          $clog2(MAX_OPTIONS + 1) : hts_pkg::MAX_OPT_W;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_ACC    = 9'b000000010,
    ST_WAIT   = 9'b000000100,
    ST_NEXT   = 9'b000001000,
    ST_SCAN   = 9'b000010000,
    ST_TAIL   = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_PUSH   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [hts_pkg::MAX_OPT_W-1:0]   option_limit;
  logic [hts_pkg::MIN_COUNT_W-1:0] min_count;
  logic [hts_pkg::TSU_W-1:0]       timeslots_used;
  logic [hts_pkg::VU_W-1:0]        venues_used;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      option_limit   <= hts_pkg::OPTION_LIMIT_RST;
      min_count      <= hts_pkg::MIN_COUNT_RST;
      timeslots_used <= hts_pkg::TIMESLOTS_USED_RST;
      venues_used    <= hts_pkg::VENUES_USED_RST;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        hts_pkg::REG_OPTION_LIMIT:   option_limit <= cfg.payload.data[hts_pkg::MAX_OPT_W-1:0];
        hts_pkg::REG_MIN_COUNT:      min_count <= cfg.payload.data[hts_pkg::MIN_COUNT_W-1:0];
        hts_pkg::REG_TIMESLOTS_USED: timeslots_used <= cfg.payload.data[hts_pkg::TSU_W-1:0];
        hts_pkg::REG_VENUES_USED:    venues_used <= cfg.payload.data[hts_pkg::VU_W-1:0];
        default: ;
      endcase
    end
  end

  logic [RA_W-1:0]  rows_act;
  logic [CA_W-1:0]  cols_act;
  logic [RND_W-1:0] rounds_lim;

  assign rows_act = (RA_W'(timeslots_used) < RA_W'(TIMESLOTS)) ?
                    RA_W'(timeslots_used) : RA_W'(TIMESLOTS);
  assign cols_act = (CA_W'(venues_used) < CA_W'(VENUES)) ?
                    CA_W'(venues_used) : CA_W'(VENUES);
  assign rounds_lim = (RND_W'(option_limit) < RND_W'(MAX_OPTIONS)) ?
                      RND_W'(option_limit) : RND_W'(MAX_OPTIONS);

  // histogram RAM: word = {taken, count}
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rd_word;

  hts_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_word)
  );

  // accumulation path
  logic              pair_acc;
  logic              pair_hit;
  logic [ADDR_W-1:0] pair_addr;
  logic              p_valid;
  logic [ADDR_W-1:0] p_addr;
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  logic [WORD_W-1:0] lw_data;
  logic [CNT_W-1:0]  acc_base;
  logic [CNT_W-1:0]  acc_next;

  assign pairs.ready = (state == ST_ACC);
  assign pair_acc    = pairs.valid && pairs.ready;
  assign pair_hit    = (RA_W'(pairs.payload.slot_index) < rows_act) &&
                       (CA_W'(pairs.payload.room_index) < cols_act);
  assign pair_addr   = ADDR_W'(32'(pairs.payload.slot_index) * VENUES +
                               32'(pairs.payload.room_index));
  assign acc_base    = (lw_valid && lw_addr == p_addr) ?
                       lw_data[CNT_W-1:0] : rd_word[CNT_W-1:0];
  assign acc_next    = (acc_base < CNT_W'(COUNT_MAX)) ? acc_base + 1'b1 : acc_base;

  // scan path
  logic [RA_W-1:0]   t;
  logic [CA_W-1:0]   v;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] row_base;
  logic              s_valid;
  logic [RA_W-1:0]   s_t;
  logic [CA_W-1:0]   s_v;
  logic [ADDR_W-1:0] s_addr;
  logic [CNT_W-1:0]  best;
  logic [RA_W-1:0]   best_t;
  logic [CA_W-1:0]   best_v;
  logic [ADDR_W-1:0] best_addr;
  logic              scan_last;
  logic              qualify;
  logic [ADDR_W-1:0] clr_addr;
  logic [RND_W-1:0]  round;

  assign raddr     = (state == ST_SCAN) ? cur_addr : pair_addr;
  assign scan_last = (t == RA_W'(rows_act - 1'b1)) && (v == CA_W'(cols_act - 1'b1));
  assign qualify   = CMP_W'(best) > CMP_W'(min_count);

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (p_valid) begin
      we    = 1'b1;
      waddr = p_addr;
      wdata = {1'b0, acc_next};
    end else if (state == ST_DECIDE && qualify) begin
      we    = 1'b1;
      waddr = best_addr;
      wdata = {1'b1, best};
    end else if (state == ST_CLEAR) begin
      we = 1'b1;
    end
  end

  // result staging
  hts_pkg::result_t pend;
  hts_pkg::result_t new_pend;
  hts_pkg::result_t none_res;
  hts_pkg::result_t out_data;
  hts_pkg::result_t out_q;
  logic             have_pending;
  logic             out_valid;
  logic             out_free;
  logic             out_push;
  logic [CMP_W-1:0] best_ext;

  assign best_ext = CMP_W'(best);
  assign out_free = !out_valid || results.ready;

  always_comb begin
    new_pend              = '0;
    new_pend.found        = 1'b1;
    new_pend.chosen_slot  = best_t[hts_pkg::SLOT_W-1:0];
    new_pend.chosen_room  = best_v[hts_pkg::ROOM_W-1:0];
    new_pend.chosen_count = best_ext[hts_pkg::COUNT_OUT_W-1:0];
    new_pend.rank         = round[hts_pkg::RANK_W-1:0];
    none_res              = '0;
    none_res.last_result  = 1'b1;
    if (state == ST_FINISH) begin
      if (have_pending) begin
        out_data             = pend;
        out_data.last_result = 1'b1;
      end else begin
        out_data = none_res;
      end
    end else begin
      out_data = pend;
    end
  end

  assign out_push = out_free &&
                    ((state == ST_PUSH && have_pending) || state == ST_FINISH);

  assign results.valid   = out_valid;
  assign results.payload = out_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      p_valid      <= 1'b0;
      lw_valid     <= 1'b0;
      s_valid      <= 1'b0;
      out_valid    <= 1'b0;
      have_pending <= 1'b0;
      round        <= '0;
    end else begin
      p_valid  <= pair_acc && pair_hit;
      lw_valid <= we;
      s_valid  <= (state == ST_SCAN);
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (pair_acc && pairs.payload.end_of_session) begin
            round        <= '0;
            have_pending <= 1'b0;
            state        <= ST_WAIT;
          end
        end
        ST_WAIT: state <= ST_NEXT;
        ST_NEXT: begin
          if (round == rounds_lim || rows_act == '0 || cols_act == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: state <= ST_DECIDE;
        ST_DECIDE: state <= qualify ? ST_PUSH : ST_FINISH;
        ST_PUSH: begin
          if (!have_pending || out_free) begin
            have_pending <= 1'b1;
            round        <= round + 1'b1;
            state        <= ST_NEXT;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            clr_addr <= '0;
            state    <= ST_CLEAR;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lw_addr <= waddr;
    lw_data <= wdata;
    if (pair_acc) begin
      p_addr <= pair_addr;
    end
    s_t    <= t;
    s_v    <= v;
    s_addr <= cur_addr;
    if (out_push) begin
      out_q <= out_data;
    end
    if (state == ST_PUSH && (!have_pending || out_free)) begin
      pend <= new_pend;
    end
    if (state == ST_NEXT) begin
      t        <= '0;
      v        <= '0;
      cur_addr <= '0;
      row_base <= '0;
      best     <= '0;
    end else if (state == ST_SCAN) begin
      if (v == CA_W'(cols_act - 1'b1)) begin
        v        <= '0;
        t        <= t + 1'b1;
        row_base <= row_base + ADDR_W'(VENUES);
        cur_addr <= row_base + ADDR_W'(VENUES);
      end else begin
        v        <= v + 1'b1;
        cur_addr <= cur_addr + 1'b1;
      end
    end
    if (s_valid && !rd_word[CNT_W] && rd_word[CNT_W-1:0] > best) begin
      best      <= rd_word[CNT_W-1:0];
      best_t    <= s_t;
      best_v    <= s_v;
      best_addr <= s_addr;
    end
  end

  a_acc_write_window: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_ACC || state == ST_WAIT))
    else $error("accumulation write outside accumulation");

  a_pending_shape: assert property (@(posedge clk) disable iff (rst)
    have_pending |-> (pend.found && !pend.last_result))
    else $error("staged result malformed");

  a_final_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=>
      (state == ST_CLEAR && results.valid && results.payload.last_result))
    else $error("session end without final result beat");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (state == ST_CLEAR && !pairs.ready && !results.valid))
    else $error("reset did not start clear pass");

endmodule
